// File: design/ramn_pkg.sv
// ----------------------------------------------------------------------------
// ramn_pkg
// shared types and codes for the mutual exclusion node: job descriptors
// passed from front to back, node modes, input item codes, result bundle
// ----------------------------------------------------------------------------
package ramn_pkg;

    // input item codes
    localparam logic [2:0] REQ_LOCAL   = 3'd0;
    localparam logic [2:0] REL_LOCAL   = 3'd1;
    localparam logic [2:0] MSG_REQUEST = 3'd2;
    localparam logic [2:0] MSG_ACK     = 3'd3;
    localparam logic [2:0] MSG_FINISH  = 3'd4;

    // outgoing message kinds
    localparam logic SEND_REQUEST = 1'b0;
    localparam logic SEND_ACK     = 1'b1;

    // configuration register indexes
    localparam logic CFG_NODE_ID    = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_REQ  = 2'd1,
        MODE_CS   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        JOB_NONE,
        JOB_ACK,
        JOB_DEFER,
        JOB_BCAST,
        JOB_RELEASE
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [3:0]  dest;      // ack target, deferred source, or own id on broadcast
        logic [3:0]  idx;       // defer write slot, or number of queued acks on release
        logic [3:0]  n_m1;      // effective node count minus one
        logic [31:0] stamp;
        mode_t       mode;
        logic [3:0]  finish;
    } job_t;

    typedef struct packed {
        logic        valid;
        logic        send_valid;
        logic [3:0]  send_dest;
        logic        send_kind;
        logic [31:0] send_stamp;
        mode_t       node_mode;
        logic [3:0]  finish_count;
        logic        last;
    } result_t;

endpackage

// File: design/ramn_front.sv
// ----------------------------------------------------------------------------
// ramn_front
// accepts and classifies items: owns the lamport clock and protocol state,
// updates it on each taken item and pushes a job descriptor for the back end
// ----------------------------------------------------------------------------
module ramn_front #(
    parameter int MAX_NODES  = 16,
    parameter int CLOCK_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [2:0]          req_type,
    input  logic [31:0]         msg_clock,
    input  logic [3:0]          msg_source,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [4:0]          cfg_data,
    output logic                push,
    output ramn_pkg::job_t      push_job
);
    import ramn_pkg::*;

    localparam int NODE_LIMIT = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int SW = (CLOCK_BITS > 32) ? CLOCK_BITS : 32;
    localparam logic [CLOCK_BITS-1:0] CLK_MAX = '1;

    logic [3:0]            node_id_reg;
    logic [4:0]            node_count_reg;
    logic [CLOCK_BITS-1:0] clock_reg, clock_next;
    logic [CLOCK_BITS-1:0] date_reg, date_next;
    mode_t                 mode_reg, mode_next;
    logic [3:0]            ack_reg, ack_next;
    logic [3:0]            dcount_reg, dcount_next;
    logic [3:0]            finish_reg, finish_next;
    job_t                  job_next;

    logic [3:0]            n_m1;
    logic [SW-1:0]         msg_wide;
    logic [CLOCK_BITS-1:0] stamp_in;
    logic [CLOCK_BITS-1:0] base;
    logic                  is_msg;
    logic                  defer;
    logic                  inc2;
    logic [CLOCK_BITS:0]   sum;
    logic [CLOCK_BITS-1:0] clk_sat;
    logic [SW-1:0]         clk_wide;
    logic [31:0]           stamp_out;
    logic [3:0]            ack_inc;

    // effective node count, clamped to the supported range
    always_comb
    begin
        if (node_count_reg < 5'd2)
            n_m1 = 4'd1;
        else if (32'(node_count_reg) > NODE_LIMIT)
            n_m1 = 4'(NODE_LIMIT - 1);
        else
            n_m1 = 4'(node_count_reg - 5'd1);
    end

    // incoming stamp clamped to the clock range
    assign msg_wide = SW'(msg_clock);
    assign stamp_in = (msg_wide > SW'(CLK_MAX)) ? CLK_MAX : msg_wide[CLOCK_BITS-1:0];

    assign is_msg = (req_type == MSG_REQUEST) || (req_type == MSG_ACK) ||
                    (req_type == MSG_FINISH);

    always_comb
    begin
        unique case (mode_reg)
            MODE_IDLE: defer = 1'b0;
            MODE_REQ:  defer = (date_reg < stamp_in) ||
                               ((date_reg == stamp_in) && (node_id_reg < msg_source));
            default:   defer = 1'b1;
        endcase
    end

    // one saturating adder: +2 covers receive tick plus send tick of an ack
    assign base    = (is_msg && (clock_reg < stamp_in)) ? stamp_in : clock_reg;
    assign inc2    = (req_type == MSG_REQUEST) && !defer;
    assign sum     = {1'b0, base} + (inc2 ? (CLOCK_BITS+1)'(2) : (CLOCK_BITS+1)'(1));
    assign clk_sat = sum[CLOCK_BITS] ? CLK_MAX : sum[CLOCK_BITS-1:0];

    assign clk_wide  = SW'(clk_sat);
    assign stamp_out = (clk_wide > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : clk_wide[31:0];

    assign ack_inc = (ack_reg == 4'd15) ? 4'd15 : ack_reg + 4'd1;

    always_comb
    begin
        clock_next  = clock_reg;
        date_next   = date_reg;
        mode_next   = mode_reg;
        ack_next    = ack_reg;
        dcount_next = dcount_reg;
        finish_next = finish_reg;
        job_next.kind  = JOB_NONE;
        job_next.dest  = msg_source;
        job_next.idx   = dcount_reg;
        job_next.n_m1  = n_m1;
        job_next.stamp = stamp_out;

        unique case (req_type)
            REQ_LOCAL:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    clock_next    = clk_sat;
                    date_next     = clk_sat;
                    ack_next      = 4'd0;
                    mode_next     = MODE_REQ;
                    job_next.kind = JOB_BCAST;
                    job_next.dest = node_id_reg;
                end
            end
            REL_LOCAL:
            begin
                if (mode_reg == MODE_CS)
                begin
                    clock_next  = clk_sat;
                    mode_next   = MODE_IDLE;
                    dcount_next = 4'd0;
                    if (dcount_reg != 4'd0)
                        job_next.kind = JOB_RELEASE;
                end
            end
            MSG_REQUEST:
            begin
                clock_next = clk_sat;
                if (!defer)
                    job_next.kind = JOB_ACK;
                else if (dcount_reg < n_m1)
                begin
                    job_next.kind = JOB_DEFER;
                    dcount_next   = dcount_reg + 4'd1;
                end
            end
            MSG_ACK:
            begin
                clock_next = clk_sat;
                if (mode_reg == MODE_REQ)
                begin
                    ack_next = ack_inc;
                    if (ack_inc >= n_m1)
                        mode_next = MODE_CS;
                end
            end
            MSG_FINISH:
            begin
                clock_next  = clk_sat;
                finish_next = (finish_reg == 4'd15) ? 4'd15 : finish_reg + 4'd1;
            end
            default:
            begin
            end
        endcase

        job_next.mode   = mode_next;
        job_next.finish = finish_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= 4'd0;
            node_count_reg <= 5'd16;
            clock_reg      <= '0;
            date_reg       <= '0;
            mode_reg       <= MODE_IDLE;
            ack_reg        <= 4'd0;
            dcount_reg     <= 4'd0;
            finish_reg     <= 4'd0;
            push           <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_NODE_ID:    node_id_reg    <= cfg_data[3:0];
                    CFG_NODE_COUNT: node_count_reg <= cfg_data;
                    default:        node_id_reg    <= node_id_reg;
                endcase
            end
            push <= accept;
            if (accept)
            begin
                clock_reg  <= clock_next;
                date_reg   <= date_next;
                mode_reg   <= mode_next;
                ack_reg    <= ack_next;
                dcount_reg <= dcount_next;
                finish_reg <= finish_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            push_job <= job_next;
    end

endmodule

// File: design/ramn_queue.sv
// ----------------------------------------------------------------------------
// ramn_queue
// two-entry job queue between the front and back ends
// ----------------------------------------------------------------------------
module ramn_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ramn_pkg::job_t push_job,
    input  logic           pop,
    output ramn_pkg::job_t pop_job,
    output logic           empty
);
    import ramn_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;

    assign empty   = (level_reg == 2'd0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                level_reg <= level_reg + 2'd1;
            else if (pop && !push)
                level_reg <= level_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: design/ramn_back.sv
// ----------------------------------------------------------------------------
// ramn_back
// carries out jobs: emits the results of a job before it pops the next, walks the
// node list on a broadcast and the deferred store on a release
module ramn_back #(
    parameter int MAX_NODES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  ramn_pkg::job_t    pop_job,
    output logic              pop,
    output ramn_pkg::result_t res
);
    import ramn_pkg::*;

    localparam int IW = $clog2(MAX_NODES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BCAST,
        ST_REL
    } state_t;

    state_t     state_reg;
    job_t       job_reg;
    logic [3:0] idx_reg;
    logic [3:0] mem [MAX_NODES];
    logic [3:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic       bcast_last;

    assign pop = (state_reg == ST_IDLE) && !empty;

    // next slot is fetched while the current one is sent
    assign rd_addr = (state_reg == ST_REL) ? IW'(idx_reg + 4'd1) : '0;

    assign bcast_last = (idx_reg == job_reg.n_m1) ||
                        ((idx_reg == job_reg.n_m1 - 4'd1) && (job_reg.dest == job_reg.n_m1));

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (pop && (pop_job.kind == JOB_DEFER))
            mem[IW'(pop_job.idx)] <= pop_job.dest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= '0;
            idx_reg   <= 4'd0;
            res       <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        job_reg          <= pop_job;
                        idx_reg          <= 4'd0;
                        res.node_mode    <= pop_job.mode;
                        res.finish_count <= pop_job.finish;
                        unique case (pop_job.kind)
                            JOB_ACK:
                            begin
                                res.valid      <= 1'b1;
                                res.send_valid <= 1'b1;
                                res.send_dest  <= pop_job.dest;
                                res.send_kind  <= SEND_ACK;
                                res.send_stamp <= pop_job.stamp;
                                res.last       <= 1'b1;
                            end
                            JOB_BCAST:
                            begin
                                res.valid      <= 1'b0;
                                res.send_stamp <= pop_job.stamp;
                                state_reg      <= ST_BCAST;
                            end
                            JOB_RELEASE:
                            begin
                                res.valid      <= 1'b0;
                                res.send_stamp <= pop_job.stamp;
                                state_reg      <= ST_REL;
                            end
                            default:
                            begin
                                res.valid      <= 1'b1;
                                res.send_valid <= 1'b0;
                                res.send_dest  <= 4'd0;
                                res.send_kind  <= SEND_REQUEST;
                                res.send_stamp <= 32'd0;
                                res.last       <= 1'b1;
                            end
                        endcase
                    end
                    else
                        res.valid <= 1'b0;
                end
                ST_BCAST:
                begin
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg != job_reg.dest)
                    begin
                        res.valid      <= 1'b1;
                        res.send_valid <= 1'b1;
                        res.send_dest  <= idx_reg;
                        res.send_kind  <= SEND_REQUEST;
                        res.last       <= bcast_last;
                        if (bcast_last)
                            state_reg <= ST_IDLE;
                    end
                    else
                        res.valid <= 1'b0;
                end
                ST_REL:
                begin
                    idx_reg        <= idx_reg + 4'd1;
                    res.valid      <= 1'b1;
                    res.send_valid <= 1'b1;
                    res.send_dest  <= rd_data_reg;
                    res.send_kind  <= SEND_ACK;
                    res.last       <= (idx_reg == job_reg.idx - 4'd1);
                    if (idx_reg == job_reg.idx - 4'd1)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    res.valid <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/ricart_agrawala_mutex_node.sv
// path: a single result passes the front job register, the queue slot and the back
// end result register; a broadcast or release first loads its job in the back end,
// and a broadcast sends no result at this node's own id; busy stays high from the
// taken item until its last result, and the next item is taken only after that;
// results are strobed for one cycle; the receiver cannot stall them
// rst_n asynchronous: clock, modes, counts cleared, node_id 0, node_count 16
// ----------------------------------------------------------------------------
// ricart_agrawala_mutex_node
// one node of distributed mutual exclusion with a saturating lamport clock:
// front end updates protocol state per item, back end emits outgoing messages
// ----------------------------------------------------------------------------
module ricart_agrawala_mutex_node #(
    parameter int MAX_NODES  = 16,
    parameter int CLOCK_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // item command port
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [31:0] msg_clock,
    input  logic [3:0]  msg_source,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    // result port
    output logic        result_valid,
    output logic        send_valid,
    output logic [3:0]  send_dest,
    output logic        send_kind,
    output logic [31:0] send_stamp,
    output logic [1:0]  node_mode,
    output logic [3:0]  finish_count,
    output logic        last
);
    import ramn_pkg::*;

    logic    accept;
    logic    busy_reg;
    logic    push;
    job_t    push_job;
    logic    pop;
    job_t    pop_job;
    logic    empty;
    result_t res;

    // an item is taken only when the previous one has fully drained
    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (accept)
            busy_reg <= 1'b1;
        else if (res.valid && res.last)
            busy_reg <= 1'b0;
    end

    // front: classify item, update clock and protocol state, build a job
    ramn_front #(
        .MAX_NODES  (MAX_NODES),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .msg_clock  (msg_clock),
        .msg_source (msg_source),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_job   (push_job)
    );

    // short job queue decoupling the two halves
    ramn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    // back: sequence the outgoing messages, owns the deferred store
    ramn_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (empty),
        .pop_job (pop_job),
        .pop     (pop),
        .res     (res)
    );

    assign result_valid = res.valid;
    assign send_valid   = res.send_valid;
    assign send_dest    = res.send_dest;
    assign send_kind    = res.send_kind;
    assign send_stamp   = res.send_stamp;
    assign node_mode    = res.node_mode;
    assign finish_count = res.finish_count;
    assign last         = res.last;

endmodule

// File: design/ramn_checker.sv
// ----------------------------------------------------------------------------
// ramn_checker
// port-level checks on the mutual exclusion node, bound to the top level
// ----------------------------------------------------------------------------
module ramn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic        send_valid,
    input logic        send_kind,
    input logic [1:0]  node_mode,
    input logic        last
);
    import ramn_pkg::*;

    // results only appear while an item is in flight
    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside busy window");

    // a taken item raises busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start");

    // last result frees the node
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !busy)
        else $error("busy held after last result");

    // an empty result always stands alone
    a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !send_valid) |-> last)
        else $error("empty result not marked last");

    // outgoing requests only go out while requesting
    a_req_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && send_valid && (send_kind == SEND_REQUEST)) |->
        (node_mode == MODE_REQ))
        else $error("request sent outside requesting mode");

endmodule

bind ricart_agrawala_mutex_node ramn_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .send_valid   (send_valid),
    .send_kind    (send_kind),
    .node_mode    (node_mode),
    .last         (last)
);

// File: tb/ricart_agrawala_mutex_node_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ricart_agrawala_mutex_node_tb
// self-checking bench for one mutual exclusion node: drives local and protocol
// items through the command port under several node settings and compares
// every strobed result with a behavioral copy of the node's protocol state
// ----------------------------------------------------------------------------

import ramn_pkg::*;

// protocol state of the node kept beside the design, plus the outgoing
// messages it still owes
class mutex_node_board;
    bit [3:0]  own_id;
    bit [4:0]  count_reg;
    bit [31:0] lclock;
    bit [31:0] req_date;
    mode_t     mode;
    bit [3:0]  acks;
    bit [3:0]  deferred [16];
    int        n_deferred;
    bit [3:0]  finishes;
    result_t   expected_sends [$];
    int        errors;
    int        checked;

    function new();
        own_id     = 4'd0;
        count_reg  = 5'd16;
        lclock     = '0;
        req_date   = '0;
        mode       = MODE_IDLE;
        acks       = '0;
        n_deferred = 0;
        finishes   = '0;
        errors     = 0;
        checked    = 0;
        foreach (deferred[i])
            deferred[i] = '0;
    endfunction

    function void set_reg(logic idx, bit [4:0] val);
        if (idx == CFG_NODE_ID)
            own_id = val[3:0];
        else
            count_reg = val;
    endfunction

    function int live_nodes();
        if (count_reg < 5'd2)
            return 2;
        if (count_reg > 5'd16)
            return 16;
        return int'(count_reg);
    endfunction

    function bit [31:0] bump(bit [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function result_t make_send(bit v, bit [3:0] dest, logic kind, bit [31:0] stamp);
        result_t r;
        r = '0;
        r.valid      = 1'b1;
        r.send_valid = v;
        r.send_dest  = dest;
        r.send_kind  = kind;
        r.send_stamp = stamp;
        return r;
    endfunction

    // accepted item: advance the state and queue the messages it causes
    function void note_item(logic [2:0] kind, bit [31:0] stamp, bit [3:0] src);
        result_t   batch [$];
        int        n;
        bit        defer;
        bit [31:0] hi;
        n = live_nodes();
        case (kind)
            REQ_LOCAL: begin
                if (mode == MODE_IDLE) begin
                    lclock   = bump(lclock);
                    req_date = lclock;
                    acks     = '0;
                    mode     = MODE_REQ;
                    for (int d = 0; d < n; d++)
                        if (d != int'(own_id))
                            batch.push_back(make_send(1'b1, 4'(d), SEND_REQUEST, lclock));
                end
            end
            REL_LOCAL: begin
                if (mode == MODE_CS) begin
                    lclock = bump(lclock);
                    mode   = MODE_IDLE;
                    for (int i = 0; i < n_deferred; i++)
                        batch.push_back(make_send(1'b1, deferred[i], SEND_ACK, lclock));
                    n_deferred = 0;
                end
            end
            MSG_REQUEST, MSG_ACK, MSG_FINISH: begin
                hi     = (lclock > stamp) ? lclock : stamp;
                lclock = bump(hi);
                if (kind == MSG_REQUEST) begin
                    if (mode == MODE_IDLE)
                        defer = 1'b0;
                    else if (mode == MODE_REQ)
                        defer = (req_date < stamp) || (req_date == stamp && own_id < src);
                    else
                        defer = 1'b1;
                    if (!defer) begin
                        lclock = bump(lclock);
                        batch.push_back(make_send(1'b1, src, SEND_ACK, lclock));
                    end else if (n_deferred < n - 1) begin
                        deferred[n_deferred] = src;
                        n_deferred++;
                    end
                end else if (kind == MSG_ACK) begin
                    if (mode == MODE_REQ) begin
                        if (acks != 4'd15)
                            acks++;
                        if (int'(acks) >= n - 1)
                            mode = MODE_CS;
                    end
                end else if (finishes != 4'd15) begin
                    finishes++;
                end
            end
            default: ;
        endcase
        if (batch.size() == 0)
            batch.push_back(make_send(1'b0, 4'd0, SEND_REQUEST, '0));
        foreach (batch[i]) begin
            batch[i].node_mode    = mode;
            batch[i].finish_count = finishes;
            batch[i].last         = (i == batch.size() - 1);
            expected_sends.push_back(batch[i]);
        end
    endfunction

    task report(string what);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(result_t got);
        result_t want;
        string   diff;
        if (expected_sends.size() == 0) begin
            report($sformatf("result to %0d kind %0b with no item waiting",
                             got.send_dest, got.send_kind));
            return;
        end
        want = expected_sends.pop_front();
        checked++;
        diff = "";
        if (got.send_valid !== want.send_valid)     diff = {diff, " send_valid"};
        if (got.send_dest !== want.send_dest)       diff = {diff, " send_dest"};
        if (got.send_kind !== want.send_kind)       diff = {diff, " send_kind"};
        if (got.send_stamp !== want.send_stamp)     diff = {diff, " send_stamp"};
        if (got.node_mode !== want.node_mode)       diff = {diff, " node_mode"};
        if (got.finish_count !== want.finish_count) diff = {diff, " finish_count"};
        if (got.last !== want.last)                 diff = {diff, " last"};
        if (diff != "")
            report($sformatf({"result %0d bad%s: got v%0b d%0d k%0b s%h m%0d f%0d l%0b",
                              " want v%0b d%0d k%0b s%h m%0d f%0d l%0b"},
                             checked, diff, got.send_valid, got.send_dest, got.send_kind,
                             got.send_stamp, got.node_mode, got.finish_count, got.last,
                             want.send_valid, want.send_dest, want.send_kind,
                             want.send_stamp, want.node_mode, want.finish_count,
                             want.last));
    endtask
endclass

module ricart_agrawala_mutex_node_tb;

    // type codes the node must ignore
    localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
    localparam logic [2:0] REQ_BAD_LAST  = 3'd7;

    // generous: every item at its longest broadcast plus the longest gap, many times over
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [31:0] msg_clock;
    logic [3:0]  msg_source;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [4:0]  cfg_data;
    logic        result_valid;
    logic        send_valid;
    logic [3:0]  send_dest;
    logic        send_kind;
    logic [31:0] send_stamp;
    logic [1:0]  node_mode;
    logic [3:0]  finish_count;
    logic        last;

    mutex_node_board sb = new();

    int  cycles        = 0;
    int  items_sent    = 0;
    int  ignored_items = 0;
    int  settings_used = 0;
    int  idle_pct      = 0;
    bit  wide_stamps   = 1'b0;

    ricart_agrawala_mutex_node uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .msg_clock    (msg_clock),
        .msg_source   (msg_source),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .send_valid   (send_valid),
        .send_dest    (send_dest),
        .send_kind    (send_kind),
        .send_stamp   (send_stamp),
        .node_mode    (node_mode),
        .finish_count (finish_count),
        .last         (last)
    );

    always #2 clk = ~clk;

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, sb.expected_sends.size());
            $display("status: fail");
            $finish;
        end
    end

    // results are strobed for one cycle and cannot be held off: take each
    // one at the edge that ends its cycle
    always @(posedge clk)
    begin : watch_results
        result_t got;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            got              = '0;
            got.valid        = 1'b1;
            got.send_valid   = send_valid;
            got.send_dest    = send_dest;
            got.send_kind    = send_kind;
            got.send_stamp   = send_stamp;
            got.node_mode    = mode_t'(node_mode);
            got.finish_count = finish_count;
            got.last         = last;
            sb.check_result(got);
        end
    end

    // present one item and hold it until the node takes it; start stays high
    // so the next item can follow back to back unless a gap is drawn
    task automatic drive_item(logic [2:0] kind, logic [31:0] stamp, logic [3:0] src);
        start      <= 1'b1;
        req_type   <= kind;
        msg_clock  <= stamp;
        msg_source <= src;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(kind, stamp, src);
        items_sent++;
        // random sender gap with start low before the next item
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20))
                @(posedge clk);
        end
    endtask

    // item types the node drops, with random fields
    task automatic send_noise();
        ignored_items++;
        drive_item(3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST)), $urandom(),
                   4'($urandom()));
    endtask

    // stop offering items and let every owed result come out
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_sends.size() != 0 || busy)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // node settings change only with nothing in flight
    task automatic set_config(logic [4:0] id_val, logic [4:0] count_val);
        drain();
        write_reg(CFG_NODE_ID, id_val);
        write_reg(CFG_NODE_COUNT, count_val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // small step around a stamp, kept from wrapping below zero
    function automatic logic [31:0] nudge(logic [31:0] base);
        int delta;
        delta = int'($urandom_range(0, 6)) - 3;
        if (base < 32'd3 && delta < 0)
            return base;
        return base + 32'(delta);
    endfunction

    // request stamps cluster on our own request date to hit both priority
    // outcomes and the equal-date tie break
    function automatic logic [31:0] pick_req_stamp();
        case ($urandom_range(0, 4))
            0: return sb.req_date;
            1: return nudge(sb.req_date);
            2: return sb.req_date + 32'd1;
            3: return nudge(sb.lclock);
            default: return wide_stamps ? 32'($urandom()) : 32'($urandom_range(0, 64));
        endcase
    endfunction

    // ack and finish stamps: mostly around the clock, some stale
    function automatic logic [31:0] pick_ack_stamp();
        case ($urandom_range(0, 3))
            0: return sb.lclock;
            1: return nudge(sb.lclock);
            2: return 32'($urandom_range(0, 64));
            default: return wide_stamps ? 32'($urandom()) : nudge(sb.lclock);
        endcase
    endfunction

    // mostly peers in range, sometimes any id including our own
    function automatic logic [3:0] pick_source();
        if ($urandom_range(0, 4) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, sb.live_nodes() - 1));
    endfunction

    // one pass of the protocol: request, collect acks amid other traffic,
    // hold the critical section while requests queue up, then release;
    // some rounds are abandoned or never released
    task automatic run_round();
        int guard;
        int roll;
        int extra;
        drive_item(REQ_LOCAL, $urandom(), pick_source());
        guard = 0;
        while (sb.mode == MODE_REQ && guard < 40)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                drive_item(MSG_ACK, pick_ack_stamp(), pick_source());
            else if (roll < 75)
                drive_item(MSG_REQUEST, pick_req_stamp(), pick_source());
            else if (roll < 83)
                drive_item(MSG_FINISH, pick_ack_stamp(), pick_source());
            else if (roll < 92)
                send_noise();
            else if (roll < 95)
                guard = 40;
            else
                drive_item(REL_LOCAL, $urandom(), pick_source());
            guard++;
        end
        if (sb.mode == MODE_CS)
        begin
            extra = $urandom_range(0, sb.live_nodes() + 1);
            repeat (extra)
            begin
                if ($urandom_range(0, 3) != 0)
                    drive_item(MSG_REQUEST, pick_req_stamp(), pick_source());
                else
                    drive_item(MSG_FINISH, pick_ack_stamp(), pick_source());
            end
            if ($urandom_range(0, 9) != 0)
                drive_item(REL_LOCAL, $urandom(), pick_source());
        end
    endtask

    task automatic run_phase(logic [4:0] id_val, logic [4:0] count_val, int pct,
                             int target, bit wide);
        int base;
        set_config(id_val, count_val);
        idle_pct    = pct;
        wide_stamps = wide;
        base        = items_sent - ignored_items;
        while (items_sent - ignored_items - base < target)
            run_round();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_LOCAL;
        msg_clock  = '0;
        msg_source = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_NODE_ID;
        cfg_data   = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: node 5 of 4, so its own id is outside the node range
        set_config(5'd5, 5'd4);
        drive_item(REL_LOCAL, 32'd0, 4'd0);          // release while idle is dropped
        drive_item(MSG_ACK, 32'd0, 4'd0);            // stray ack only moves the clock
        drive_item(MSG_FINISH, 32'd10, 4'd15);
        drive_item(MSG_REQUEST, 32'd2, 4'd3);        // idle node acks at once
        for (int k = REQ_BAD_FIRST; k <= REQ_BAD_LAST; k++)
            drive_item(3'(k), $urandom(), 4'($urandom()));
        drive_item(REQ_LOCAL, 32'd0, 4'd0);          // broadcast to all four
        drive_item(REQ_LOCAL, 32'd0, 4'd0);          // second request while requesting
        drive_item(MSG_REQUEST, sb.req_date, 4'd6);  // equal date, we win the tie: queued
        drive_item(MSG_REQUEST, sb.req_date, 4'd4);  // equal date, they win: acked
        drive_item(MSG_REQUEST, sb.req_date - 32'd1, 4'd1); // earlier date: acked
        drive_item(MSG_REQUEST, sb.req_date + 32'd1, 4'd2); // later date: queued
        drive_item(REL_LOCAL, 32'd0, 4'd0);          // release before entering
        drive_item(MSG_ACK, sb.lclock, 4'd0);
        drive_item(MSG_ACK, sb.lclock, 4'd1);
        drive_item(MSG_ACK, sb.lclock, 4'd2);        // last needed ack enters
        drive_item(MSG_REQUEST, 32'd1, 4'd0);        // in section: queue now full
        drive_item(MSG_REQUEST, 32'd1, 4'd9);        // queue full: dropped silently
        drive_item(MSG_ACK, 32'd0, 4'd3);            // ack while inside
        drive_item(REL_LOCAL, 32'd0, 4'd0);          // acks every queued node

        // random protocol traffic under several node settings and sender rates
        run_phase(5'd0, 5'd16, 0, 70, 1'b0);
        run_phase(5'h1F, 5'd2, 55, 70, 1'b0);
        run_phase(5'd7, 5'd9, 15, 100, 1'b0);
        run_phase(5'd12, 5'd0, 55, 40, 1'b0);
        run_phase(5'd9, 5'd31, 15, 30, 1'b1);

        // the clock never goes back, so saturation is left for the very end
        drive_item(MSG_ACK, 32'hFFFF_FFFE, 4'd1);
        drive_item(MSG_REQUEST, 32'hFFFF_FFFF, 4'd2);
        drive_item(MSG_FINISH, 32'hFFFF_FFFF, 4'd15);
        run_round();
        run_round();

        drain();
        repeat (25)
            @(posedge clk);

        $display("ran %0d items (%0d of dropped types) over %0d node settings",
                 items_sent, ignored_items, settings_used);
        $display("checked %0d results, %0d mismatches, clock ended at %h",
                 sb.checked, sb.errors, sb.lclock);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
design/ramn_pkg.sv
design/ramn_front.sv
design/ramn_queue.sv
design/ramn_back.sv
design/ricart_agrawala_mutex_node.sv
design/ramn_checker.sv
tb/ricart_agrawala_mutex_node_tb.sv
